### hw/rtl/assert_macros.svh
// Assertion macros for the checker file lcp_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every clock edge outside reset.
`define LCP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lcp assertion failed");

// Check prop at every clock edge, reset included.
`define LCP_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("lcp reset assertion failed");

`endif

### hw/rtl/lcp_pkg.sv
// Constants and types for the lamp command parser.
// No dependencies.
`default_nettype none

package lcp_pkg;

   localparam logic [7:0] CHAR_L      = 8'h4C;
   localparam logic [7:0] CHAR_R      = 8'h52;
   localparam logic [7:0] CHAR_G      = 8'h47;
   localparam logic [7:0] CHAR_B      = 8'h42;
   localparam logic [7:0] CHAR_G_LOW  = 8'h67;
   localparam logic [7:0] CHAR_ON     = 8'h31;
   localparam logic [7:0] CHAR_OFF    = 8'h30;
   localparam logic [7:0] CHAR_TOGGLE = 8'h54;

   localparam logic [1:0] LAMP_RED       = 2'd0;
   localparam logic [1:0] LAMP_GREEN     = 2'd1;
   localparam logic [1:0] LAMP_BLUE      = 2'd2;
   localparam logic [1:0] LAMP_GREEN_TWO = 2'd3;
   localparam logic [2:0] LAMP_NONE      = 3'd4;

   typedef enum logic [2:0] {
      STAGE_IDLE = 3'b001,
      STAGE_LAMP = 3'b010,
      STAGE_OP   = 3'b100
   } stage_type;

endpackage

`default_nettype wire

### hw/rtl/lcp_if.sv
// Valid/ready channels of the lamp command parser: received bytes and lamp results.
// No dependencies.
`default_nettype none

interface lcp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface lcp_rsp_if;
   logic       valid;
   logic       ready;
   logic       lamp_red;
   logic       lamp_green;
   logic       lamp_blue;
   logic       lamp_green_two;
   logic       command_done;
   logic [2:0] recorded_lamp;

   modport source (output valid, output lamp_red, output lamp_green, output lamp_blue,
                   output lamp_green_two, output command_done, output recorded_lamp,
                   input ready);
   modport sink (input valid, input lamp_red, input lamp_green, input lamp_blue,
                 input lamp_green_two, input command_done, input recorded_lamp,
                 output ready);
endinterface

`default_nettype wire

### hw/rtl/led_command_parser_unit.sv
// Lamp command parser top level: decodes "L<lamp><op>" byte commands into lamp states.
// Depends on lcp_pkg and the channel interfaces in lcp_if.sv.
//
//   channel   dir  payload                                   transfer
//   req_chan  in   rx_byte                                   valid && ready
//   rsp_chan  out  lamp_red/green/blue/green_two, done, rec  valid && ready
//
// One byte per cycle sustained while the result side takes each result.
// Bytes land in an input register, are decoded and applied to the lamp state in one
// pass, and the result is held in an output register until its transfer.
// While a result stalls, the input register still takes one more byte.
// Synchronous reset: lamps dark, no recorded lamp, parser idle, both registers empty.
`default_nettype none

module led_command_parser_unit
   import lcp_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   lcp_req_if.sink     req_chan,
   lcp_rsp_if.source   rsp_chan
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] byte_ff, byte_in;
   stage_type  stage_ff, stage_in;
   logic [1:0] held_ff, held_in;
   logic [3:0] lamps_ff, lamps_in;
   logic [2:0] last_ff, last_in;
   logic       out_valid_ff, out_valid_in;
   logic       done_ff, done_in;
   logic [3:0] out_lamps_ff, out_lamps_in;
   logic [2:0] out_last_ff, out_last_in;

   logic       advance;
   logic       req_xfer;
   logic       is_lamp;
   logic [1:0] lamp_idx;
   logic       is_op;

   assign advance  = !out_valid_ff || rsp_chan.ready;
   assign req_xfer = req_chan.valid && req_chan.ready;

   assign req_chan.ready          = !in_valid_ff || advance;
   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.lamp_red       = out_lamps_ff[0];
   assign rsp_chan.lamp_green     = out_lamps_ff[1];
   assign rsp_chan.lamp_blue      = out_lamps_ff[2];
   assign rsp_chan.lamp_green_two = out_lamps_ff[3];
   assign rsp_chan.command_done   = done_ff;
   assign rsp_chan.recorded_lamp  = out_last_ff;

   always_comb begin
      is_lamp  = 1'b1;
      lamp_idx = LAMP_RED;
      case (byte_ff)
         CHAR_R:     lamp_idx = LAMP_RED;
         CHAR_G:     lamp_idx = LAMP_GREEN;
         CHAR_B:     lamp_idx = LAMP_BLUE;
         CHAR_G_LOW: lamp_idx = LAMP_GREEN_TWO;
         default:    is_lamp = 1'b0;
      endcase
   end

   assign is_op = (byte_ff == CHAR_ON) || (byte_ff == CHAR_OFF) || (byte_ff == CHAR_TOGGLE);

   always_comb begin
      stage_in = stage_ff;
      held_in  = held_ff;
      lamps_in = lamps_ff;
      last_in  = last_ff;
      done_in  = 1'b0;
      if (advance && in_valid_ff) begin
         stage_in = (byte_ff == CHAR_L) ? STAGE_LAMP : STAGE_IDLE;
         case (stage_ff)
            STAGE_LAMP: begin
               if (is_lamp) begin
                  held_in  = lamp_idx;
                  stage_in = STAGE_OP;
               end
            end
            STAGE_OP: begin
               if (is_op) begin
                  done_in  = 1'b1;
                  stage_in = STAGE_IDLE;
                  if (byte_ff == CHAR_ON) begin
                     lamps_in[held_ff] = 1'b1;
                     last_in           = {1'b0, held_ff};
                  end else if (byte_ff == CHAR_OFF) begin
                     lamps_in[held_ff] = 1'b0;
                  end else if (last_ff != {1'b0, held_ff}) begin
                     if (last_ff != LAMP_NONE) begin
                        lamps_in[last_ff[1:0]] = 1'b0;
                     end
                     lamps_in[held_ff] = 1'b1;
                     last_in           = {1'b0, held_ff};
                  end else begin
                     lamps_in[held_ff] = 1'b0;
                     last_in           = LAMP_NONE;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      byte_in      = req_xfer ? req_chan.rx_byte : byte_ff;
      in_valid_in  = req_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? in_valid_ff : out_valid_ff;
      out_lamps_in = (advance && in_valid_ff) ? lamps_in : out_lamps_ff;
      out_last_in  = (advance && in_valid_ff) ? last_in : out_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         stage_ff     <= STAGE_IDLE;
         held_ff      <= LAMP_RED;
         lamps_ff     <= 4'b0000;
         last_ff      <= LAMP_NONE;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         stage_ff     <= stage_in;
         held_ff      <= held_in;
         lamps_ff     <= lamps_in;
         last_ff      <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      out_lamps_ff <= out_lamps_in;
      out_last_ff  <= out_last_in;
      if (advance) begin
         done_ff <= done_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/lcp_checker.sv
// Port-level checks for the lamp command parser, bound to led_command_parser_unit.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lcp_checker (
   input wire       clock,
   input wire       reset,
   input wire       req_ready,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire [2:0] rsp_recorded_lamp
);

   `LCP_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   `LCP_ASSERT(a_record_range, clock, reset, rsp_valid |-> rsp_recorded_lamp <= 3'd4)
   `LCP_ASSERT(a_ready_when_empty, clock, reset, !rsp_valid |-> req_ready)
   `LCP_ASSERT_NR(a_reset_empty, clock, reset |=> !rsp_valid)

endmodule

bind led_command_parser_unit lcp_checker u_lcp_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_recorded_lamp (rsp_chan.recorded_lamp)
);

`default_nettype wire

### dv/testbench.sv
// Self-checking testbench for led_command_parser_unit: drives received bytes and
// predicts lamp states, command completion and the recorded lamp for each transfer.
// Depends on lcp_pkg, the channel interfaces in lcp_if.sv and the RTL of the block.
`timescale 1ns / 1ps

module testbench;
   import lcp_pkg::*;

   localparam int ITEM_COUNT  = 1850;
   localparam int CALM_FROM   = 1650;
   localparam int CYCLE_LIMIT = 500000;

   typedef struct packed {
      logic       red;
      logic       green;
      logic       blue;
      logic       green_two;
      logic       done;
      logic [2:0] recorded;
   } lamp_result_type;

   class lamp_tracker;
      stage_type       stage    = STAGE_IDLE;
      logic [1:0]      held     = LAMP_RED;
      logic [3:0]      lit      = 4'b0000;
      logic [2:0]      recorded = LAMP_NONE;
      lamp_result_type due_lamps[$];
      int              errors   = 0;

      function void run_op(logic [7:0] op);
         if (op == CHAR_ON) begin
            lit[held] = 1'b1;
            recorded  = {1'b0, held};
         end else if (op == CHAR_OFF) begin
            lit[held] = 1'b0;
         end else if (recorded != {1'b0, held}) begin
            if (recorded < LAMP_NONE) lit[recorded[1:0]] = 1'b0;
            lit[held] = 1'b1;
            recorded  = {1'b0, held};
         end else begin
            lit[held] = 1'b0;
            recorded  = LAMP_NONE;
         end
      endfunction

      function void take_byte(logic [7:0] c);
         logic done;
         done = 1'b0;
         case (stage)
            STAGE_LAMP: begin
               case (c)
                  CHAR_R:     begin held = LAMP_RED;       stage = STAGE_OP; end
                  CHAR_G:     begin held = LAMP_GREEN;     stage = STAGE_OP; end
                  CHAR_B:     begin held = LAMP_BLUE;      stage = STAGE_OP; end
                  CHAR_G_LOW: begin held = LAMP_GREEN_TWO; stage = STAGE_OP; end
                  CHAR_L:     stage = STAGE_LAMP;
                  default:    stage = STAGE_IDLE;
               endcase
            end
            STAGE_OP: begin
               if (c == CHAR_ON || c == CHAR_OFF || c == CHAR_TOGGLE) begin
                  run_op(c);
                  done  = 1'b1;
                  stage = STAGE_IDLE;
               end else if (c == CHAR_L) begin
                  stage = STAGE_LAMP;
               end else begin
                  stage = STAGE_IDLE;
               end
            end
            default: begin
               if (c == CHAR_L) stage = STAGE_LAMP;
               else stage = STAGE_IDLE;
            end
         endcase
         due_lamps.push_back('{lit[0], lit[1], lit[2], lit[3], done, recorded});
      endfunction

      function void compare_field(string field, int want, int got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            errors++;
         end
      endfunction

      function void check_lamps(lamp_result_type got);
         lamp_result_type want;
         if (due_lamps.size() == 0) begin
            $error("result transfer with no byte outstanding");
            errors++;
            return;
         end
         want = due_lamps.pop_front();
         compare_field("lamp_red", want.red, got.red);
         compare_field("lamp_green", want.green, got.green);
         compare_field("lamp_blue", want.blue, got.blue);
         compare_field("lamp_green_two", want.green_two, got.green_two);
         compare_field("command_done", want.done, got.done);
         compare_field("recorded_lamp", want.recorded, got.recorded);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   bit          calm = 1'b0;
   int          sent = 0;
   int          cycle_count = 0;
   lamp_tracker tracker;

   lcp_req_if req_chan ();
   lcp_rsp_if rsp_chan ();

   led_command_parser_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) tracker.take_byte(req_chan.rx_byte);
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         tracker.check_lamps('{rsp_chan.lamp_red, rsp_chan.lamp_green, rsp_chan.lamp_blue,
                               rsp_chan.lamp_green_two, rsp_chan.command_done,
                               rsp_chan.recorded_lamp});
   end

   // stall the result side in bursts
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= b;
      do @(posedge clock); while (!req_chan.ready);
      sent++;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   task automatic send_command(input logic [7:0] lamp_char, input logic [7:0] op_char);
      send_byte(CHAR_L);
      send_byte(lamp_char);
      send_byte(op_char);
   endtask

   function automatic logic [7:0] any_lamp_char();
      case ($urandom_range(0, 3))
         0:       return CHAR_R;
         1:       return CHAR_G;
         2:       return CHAR_B;
         default: return CHAR_G_LOW;
      endcase
   endfunction

   function automatic logic [7:0] any_op_char();
      case ($urandom_range(0, 2))
         0:       return CHAR_ON;
         1:       return CHAR_OFF;
         default: return CHAR_TOGGLE;
      endcase
   endfunction

   function automatic logic [7:0] any_char();
      case ($urandom_range(0, 3))
         0:       return any_lamp_char();
         1:       return any_op_char();
         2:       return CHAR_L;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   initial begin
      int pick;
      tracker = new;
      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.rx_byte <= 8'h00;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_byte(8'h00);
      send_byte(8'hFF);
      send_command(CHAR_R, CHAR_ON);
      send_command(CHAR_G, CHAR_TOGGLE);
      send_command(CHAR_G, CHAR_TOGGLE);
      send_command(CHAR_B, CHAR_TOGGLE);
      send_byte(CHAR_L);
      send_byte(CHAR_G_LOW);
      send_command(CHAR_G_LOW, CHAR_OFF);
      send_byte(CHAR_L);
      send_command(CHAR_R, CHAR_OFF);
      send_byte(CHAR_L);
      send_byte(CHAR_ON);
      send_byte(CHAR_TOGGLE);

      while (sent < ITEM_COUNT) begin
         if (sent >= CALM_FROM) calm = 1'b1;
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            send_command(any_lamp_char(), any_op_char());
         end else if (pick == 7) begin
            send_byte(8'($urandom_range(0, 255)));
         end else if (pick == 8) begin
            send_byte(CHAR_L);
            send_byte(any_char());
         end else begin
            send_byte(CHAR_L);
            send_byte(any_lamp_char());
            send_byte(any_char());
         end
      end
      req_chan.valid <= 1'b0;

      @(posedge clock);
      while (tracker.due_lamps.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (tracker.errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
